### hw/rtl/prc_pkg.sv
// shared types and constants for the pump rest-cycle controller
// no dependencies; imported by prc_step and pump_rest_cycle_controller
`default_nettype none

package prc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_ANTI  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    REG_REST_INTERVAL = 2'd0,
    REG_REST_TIME     = 2'd1,
    REG_INVERT        = 2'd2
  } reg_index_t;

  localparam int unsigned SEC_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [SEC_W-1:0] SEC_MAX       = 16'hFFFF;
  localparam logic [3:0]       ON_BASE_TICKS = 4'd6;
  localparam logic [3:0]       OFF_TICKS     = 4'd8;

  typedef struct packed {
    logic             recirculating;
    logic             resting;
    logic             pump_drive;
    logic [1:0]       quarter_count;
    logic [SEC_W-1:0] run_seconds;
    logic [SEC_W-1:0] rest_seconds;
    logic             sequence_active;
    logic [2:0]       pulse_index;
    logic             pulse_phase_off;
    logic [3:0]       phase_ticks;
  } prc_state_t;

  typedef struct packed {
    logic sequence_done;
    logic sequence_busy;
    logic beep;
    logic resting_status;
    logic pump_on;
    logic pump_pin;
  } prc_result_t;

endpackage

`default_nettype wire

### hw/rtl/prc_step.sv
// next-state and result logic for one command word of the pump controller
// depends on prc_pkg
`default_nettype none

module prc_step #(
  parameter int unsigned PULSE_COUNT = 5
) (
  input  prc_pkg::prc_state_t      st,
  input  prc_pkg::command_t        command,
  input  logic                     pid_acting,
  input  logic [prc_pkg::SEC_W-1:0] rest_interval_s,
  input  logic [prc_pkg::SEC_W-1:0] rest_time_s,
  input  logic                     invert_output,
  output prc_pkg::prc_state_t      st_next,
  output prc_pkg::prc_result_t     result
);
  import prc_pkg::*;

  localparam logic [3:0] PULSE_LAST = 4'(PULSE_COUNT);

  logic beep;
  logic done;

  always_comb begin
    st_next = st;
    beep    = 1'b0;
    done    = 1'b0;

    if (command == CMD_TICK) begin
      st_next.quarter_count = st.quarter_count + 2'd1;
      if (st_next.quarter_count == 2'd0) begin
        if (st.run_seconds != SEC_MAX) st_next.run_seconds = st.run_seconds + 16'd1;
        if (st.rest_seconds != SEC_MAX) st_next.rest_seconds = st.rest_seconds + 16'd1;
      end
      if (st.sequence_active) begin
        st_next.phase_ticks = st.phase_ticks + 4'd1;
        if (!st.pulse_phase_off) begin
          // on time of pulse k is 7+k ticks
          if (st_next.phase_ticks >= ON_BASE_TICKS + 4'd1 + {1'b0, st.pulse_index}) begin
            st_next.pump_drive      = 1'b0;
            st_next.pulse_phase_off = 1'b1;
            st_next.phase_ticks     = 4'd0;
          end
        end else if (st_next.phase_ticks >= OFF_TICKS) begin
          st_next.phase_ticks     = 4'd0;
          st_next.pulse_phase_off = 1'b0;
          if ({1'b0, st.pulse_index} + 4'd1 >= PULSE_LAST) begin
            st_next.sequence_active = 1'b0;
            st_next.pulse_index     = 3'd0;
            done                    = 1'b1;
          end else begin
            st_next.pulse_index = st.pulse_index + 3'd1;
            st_next.pump_drive  = 1'b1;
          end
        end
      end
    end else if (!st.sequence_active) begin
      case (command)
        CMD_START: begin
          st_next.pump_drive    = 1'b1;
          st_next.recirculating = 1'b1;
          st_next.run_seconds   = '0;
          st_next.rest_seconds  = SEC_MAX;
        end
        CMD_STOP: begin
          st_next.pump_drive    = 1'b0;
          st_next.recirculating = 1'b0;
          st_next.run_seconds   = SEC_MAX;
          st_next.rest_seconds  = SEC_MAX;
        end
        CMD_ANTI: begin
          st_next.sequence_active = 1'b1;
          st_next.pulse_index     = 3'd0;
          st_next.pulse_phase_off = 1'b0;
          st_next.phase_ticks     = 4'd0;
          st_next.pump_drive      = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // rest check follows every tick, start and stop outside the sequence
    if (!st.sequence_active && command != CMD_ANTI && st_next.recirculating && !pid_acting) begin
      if (!st_next.resting && st_next.run_seconds >= rest_interval_s) begin
        st_next.pump_drive   = 1'b0;
        st_next.resting      = 1'b1;
        st_next.run_seconds  = SEC_MAX;
        st_next.rest_seconds = '0;
        beep                 = 1'b1;
      end
      if (st_next.resting && st_next.rest_seconds >= rest_time_s) begin
        st_next.pump_drive   = 1'b1;
        st_next.resting      = 1'b0;
        st_next.rest_seconds = SEC_MAX;
        st_next.run_seconds  = '0;
        beep                 = 1'b1;
      end
    end
  end

  always_comb begin
    result.pump_pin       = st_next.pump_drive ^ invert_output;
    result.pump_on        = st_next.pump_drive;
    result.resting_status = st_next.resting & st_next.recirculating & ~pid_acting;
    result.beep           = beep;
    result.sequence_busy  = st_next.sequence_active;
    result.sequence_done  = done;
  end

endmodule

`default_nettype wire

### hw/rtl/pump_rest_cycle_controller.sv
// result path: a word is captured in the input register, then its result in the result register
// throughput: one command word per cycle while m_tready stays high; the state update is a single
//   registered pass through prc_step
// reset: synchronous, clears state, config to 600 s / 60 s / non-inverted, both stages empty
// top level: input stage, controller state, config registers, result stage; uses prc_step
`default_nettype none

module pump_rest_cycle_controller #(
  parameter int unsigned PULSE_COUNT = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [1:0] command, [2] pid_acting, [7:3] zero
  input  logic [prc_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] pump_pin, [1] pump_on, [2] resting_status, [3] beep,
  // [4] sequence_busy, [5] sequence_done, [7:6] zero
  output logic [prc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import prc_pkg::*;

  logic [SEC_W-1:0] rest_interval_s;
  logic [SEC_W-1:0] rest_time_s;
  logic             invert_output;

  logic     in_valid;
  command_t in_command;
  logic     in_pid;

  prc_state_t  st;
  prc_state_t  st_next;
  prc_result_t result;
  prc_result_t out_result;

  logic out_take;
  logic advance;

  assign out_take = ~m_tvalid | m_tready;
  assign advance  = in_valid & out_take;
  assign s_tready = ~in_valid | out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_interval_s <= 16'd600;
      rest_time_s     <= 16'd60;
      invert_output   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_REST_INTERVAL: rest_interval_s <= cfg_data;
        REG_REST_TIME:     rest_time_s     <= cfg_data;
        REG_INVERT:        invert_output   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command <= command_t'(s_tdata[1:0]);
      in_pid     <= s_tdata[2];
    end
  end

  prc_step #(
    .PULSE_COUNT(PULSE_COUNT)
  ) u_step (
    .st              (st),
    .command         (in_command),
    .pid_acting      (in_pid),
    .rest_interval_s (rest_interval_s),
    .rest_time_s     (rest_time_s),
    .invert_output   (invert_output),
    .st_next         (st_next),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(prc_result_t)){1'b0}}, out_result};

`ifndef ASSERT_OFF
  // idle sequencer fields always rest at zero
  assert property (@(posedge clk) disable iff (rst)
    !st.sequence_active |-> (st.pulse_index == 3'd0 && !st.pulse_phase_off &&
                             st.phase_ticks == 4'd0))
    else $error("sequencer fields not cleared while idle");

  assert property (@(posedge clk) disable iff (rst)
    st.sequence_active |-> ({1'b0, st.pulse_index} < 4'(PULSE_COUNT)))
    else $error("pulse index beyond pulse count");

  assert property (@(posedge clk) disable iff (rst)
    (st.sequence_active && !st.pulse_phase_off) |->
      (st.phase_ticks < ON_BASE_TICKS + 4'd1 + {1'b0, st.pulse_index}))
    else $error("on phase overran its length");

  assert property (@(posedge clk) disable iff (rst)
    (st.sequence_active && st.pulse_phase_off) |-> (st.phase_ticks < OFF_TICKS))
    else $error("off phase overran its length");

  // state only moves when a word goes into the result register
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("state changed without a word advancing");
`endif

endmodule

`default_nettype wire

### sim/tb_pump_rest_cycle_controller.sv
// self-checking testbench for pump_rest_cycle_controller: command words go in on the s_ stream,
// a local predictor computes each status word, and the m_ stream output is checked against it
// depends on prc_pkg and the pump_rest_cycle_controller rtl
module tb_pump_rest_cycle_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import prc_pkg::*;

  localparam int unsigned PULSES = 5;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // [1:0] command, [2] pid_acting, [7:3] zero
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b1;
  // [0] pump_pin, [1] pump_on, [2] resting_status, [3] beep,
  // [4] sequence_busy, [5] sequence_done, [7:6] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pump_rest_cycle_controller #(.PULSE_COUNT(PULSES)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted controller state and register copy
  prc_state_t ctl;
  logic [SEC_W-1:0] rest_interval;
  logic [SEC_W-1:0] rest_time;
  logic invert_pin;

  prc_result_t status_q[$];

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned beeps_seen = 0;
  int unsigned sequences_done = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit send_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SEC_W-1:0] sec_inc(logic [SEC_W-1:0] v);
    return (v == SEC_MAX) ? SEC_MAX : v + 16'd1;
  endfunction

  // rest start and rest end, both may fire in one word
  function automatic logic apply_rest_rule(logic pid);
    logic changed;
    changed = 1'b0;
    if (ctl.recirculating && !pid) begin
      if (!ctl.resting && ctl.run_seconds >= rest_interval) begin
        ctl.pump_drive = 1'b0;
        ctl.resting = 1'b1;
        ctl.run_seconds = SEC_MAX;
        ctl.rest_seconds = '0;
        changed = 1'b1;
      end
      if (ctl.resting && ctl.rest_seconds >= rest_time) begin
        ctl.pump_drive = 1'b1;
        ctl.resting = 1'b0;
        ctl.rest_seconds = SEC_MAX;
        ctl.run_seconds = '0;
        changed = 1'b1;
      end
    end
    return changed;
  endfunction

  function automatic prc_result_t predict_status(command_t cmd, logic pid);
    prc_result_t r;
    logic beep_now;
    logic done_now;
    beep_now = 1'b0;
    done_now = 1'b0;
    if (cmd == CMD_TICK) begin
      ctl.quarter_count = ctl.quarter_count + 2'd1;
      if (ctl.quarter_count == 2'd0) begin
        ctl.run_seconds = sec_inc(ctl.run_seconds);
        ctl.rest_seconds = sec_inc(ctl.rest_seconds);
      end
      if (ctl.sequence_active) begin
        ctl.phase_ticks = ctl.phase_ticks + 4'd1;
        if (!ctl.pulse_phase_off) begin
          if (int'(ctl.phase_ticks) >= int'(ON_BASE_TICKS) + 1 + int'(ctl.pulse_index)) begin
            ctl.pump_drive = 1'b0;
            ctl.pulse_phase_off = 1'b1;
            ctl.phase_ticks = '0;
          end
        end else if (ctl.phase_ticks >= OFF_TICKS) begin
          ctl.phase_ticks = '0;
          ctl.pulse_phase_off = 1'b0;
          if (int'(ctl.pulse_index) + 1 >= int'(PULSES)) begin
            ctl.sequence_active = 1'b0;
            ctl.pulse_index = '0;
            done_now = 1'b1;
          end else begin
            ctl.pulse_index = ctl.pulse_index + 3'd1;
            ctl.pump_drive = 1'b1;
          end
        end
      end else begin
        beep_now = apply_rest_rule(pid);
      end
    end else if (!ctl.sequence_active) begin
      case (cmd)
        CMD_START: begin
          ctl.pump_drive = 1'b1;
          ctl.recirculating = 1'b1;
          ctl.run_seconds = '0;
          ctl.rest_seconds = SEC_MAX;
          beep_now = apply_rest_rule(pid);
        end
        CMD_STOP: begin
          ctl.pump_drive = 1'b0;
          ctl.recirculating = 1'b0;
          ctl.run_seconds = SEC_MAX;
          ctl.rest_seconds = SEC_MAX;
          beep_now = apply_rest_rule(pid);
        end
        default: begin
          ctl.sequence_active = 1'b1;
          ctl.pulse_index = '0;
          ctl.pulse_phase_off = 1'b0;
          ctl.phase_ticks = '0;
          ctl.pump_drive = 1'b1;
        end
      endcase
    end
    r.pump_pin = ctl.pump_drive ^ invert_pin;
    r.pump_on = ctl.pump_drive;
    r.resting_status = ctl.resting & ctl.recirculating & ~pid;
    r.beep = beep_now;
    r.sequence_busy = ctl.sequence_active;
    r.sequence_done = done_now;
    return r;
  endfunction

  function automatic logic pick_pid();
    return ($urandom_range(0, 7) == 0);
  endfunction

  task automatic send_command(command_t cmd, logic pid);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-3){1'b0}}, pid, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    status_q.push_back(predict_status(cmd, pid));
    words_sent++;
  endtask

  // only written with the controller drained
  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REST_INTERVAL: rest_interval = val;
      REG_REST_TIME: rest_time = val;
      default: invert_pin = val[0];
    endcase
    reg_writes++;
  endtask

  task automatic report_bit(string name, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // status word checker
  always @(posedge clk) begin
    prc_result_t exp_w;
    prc_result_t act_w;
    if (!rst && m_tvalid && m_tready) begin
      act_w = prc_result_t'(m_tdata[5:0]);
      if (status_q.size() == 0) begin
        $display("%0t: unexpected status word, expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        exp_w = status_q.pop_front();
        report_bit("pump_pin", exp_w.pump_pin, act_w.pump_pin);
        report_bit("pump_on", exp_w.pump_on, act_w.pump_on);
        report_bit("resting_status", exp_w.resting_status, act_w.resting_status);
        report_bit("beep", exp_w.beep, act_w.beep);
        report_bit("sequence_busy", exp_w.sequence_busy, act_w.sequence_busy);
        report_bit("sequence_done", exp_w.sequence_done, act_w.sequence_done);
        if (m_tdata[7:6] !== 2'b00) begin
          $display("%0t: pad mismatch, expected 0 actual %b", $time, m_tdata[7:6]);
          errors++;
        end
        words_checked++;
        if (exp_w.beep) beeps_seen++;
        if (exp_w.sequence_done) sequences_done++;
      end
    end
  end

  // sink back-pressure in random bursts while sink_stalls is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles, %0d words still expected",
             $time, QUIET_LIMIT, status_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // default registers 600 s / 60 s, pin not inverted
  task automatic test_reset_defaults();
    send_command(CMD_TICK, 1'b0);
    send_command(CMD_START, 1'b0);
    send_command(CMD_TICK, 1'b1);
    send_command(CMD_STOP, 1'b0);
    send_command(CMD_TICK, 1'b0);
  endtask

  task automatic test_rest_extremes();
    write_reg(REG_REST_INTERVAL, 16'd0);
    write_reg(REG_REST_TIME, 16'd0);
    write_reg(REG_INVERT, 16'd1);
    send_command(CMD_START, 1'b1);    // pid acting holds off the rest
    send_command(CMD_TICK, 1'b0);     // rest begins and ends in one word
    send_command(CMD_START, 1'b0);
    send_command(CMD_STOP, 1'b0);
    send_command(CMD_TICK, 1'b0);
    write_reg(REG_REST_INTERVAL, 16'd1);
    write_reg(REG_REST_TIME, 16'hFFFF);
    write_reg(REG_INVERT, 16'd0);
    send_command(CMD_START, 1'b0);
    repeat (4) send_command(CMD_TICK, 1'b0);
    send_command(CMD_TICK, 1'b1);
    // stop keeps the resting flag, the next start wakes on a saturated counter
    send_command(CMD_STOP, 1'b0);
    send_command(CMD_TICK, 1'b0);
    send_command(CMD_START, 1'b0);
    write_reg(REG_REST_INTERVAL, 16'hFFFF);
    send_command(CMD_START, 1'b0);
    send_command(CMD_TICK, 1'b0);
  endtask

  // whole pulse train with start, stop and repeated requests mixed in
  task automatic test_anti_cavitation();
    int unsigned r;
    write_reg(REG_REST_INTERVAL, 16'd2);
    write_reg(REG_REST_TIME, 16'd1);
    write_reg(REG_INVERT, 16'd1);
    send_command(CMD_START, 1'b0);
    send_command(CMD_ANTI, 1'b0);
    while (ctl.sequence_active) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_command(CMD_START, pick_pid());
      else if (r < 10) send_command(CMD_STOP, pick_pid());
      else if (r < 15) send_command(CMD_ANTI, pick_pid());
      else send_command(CMD_TICK, pick_pid());
    end
    repeat (3) send_command(CMD_TICK, 1'b0);
  endtask

  task automatic test_random_phase(int unsigned n_words, logic [SEC_W-1:0] interval_s,
                                   logic [SEC_W-1:0] rest_s, logic inv, bit gaps);
    int unsigned stop_at;
    int unsigned r;
    write_reg(REG_REST_INTERVAL, interval_s);
    write_reg(REG_REST_TIME, rest_s);
    write_reg(REG_INVERT, {15'd0, inv});
    send_gaps = gaps;
    sink_stalls = gaps;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        // unstructured noise
        repeat ($urandom_range(1, 8)) send_command(command_t'($urandom_range(0, 3)), pick_pid());
      end else begin
        // one run: start, ticks with occasional other commands, maybe a stop
        send_command(CMD_START, pick_pid());
        repeat ($urandom_range(4, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 4) send_command(CMD_STOP, pick_pid());
          else if (r < 8) send_command(CMD_START, pick_pid());
          else if (r < 10) send_command(CMD_ANTI, pick_pid());
          else send_command(CMD_TICK, pick_pid());
        end
        if ($urandom_range(0, 1) == 0) send_command(CMD_STOP, pick_pid());
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_REST_INTERVAL;
    cfg_data <= '0;
    ctl = '0;
    rest_interval = 16'd600;
    rest_time = 16'd60;
    invert_pin = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_rest_extremes();
    test_anti_cavitation();
    test_random_phase(100, 16'd1, 16'd1, 1'b0, 1'b1);
    test_random_phase(100, 16'd0, 16'd2, 1'b1, 1'b1);
    test_random_phase(100, 16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                      1'($urandom_range(0, 1)), 1'b1);
    test_random_phase(100, 16'hFFFF, 16'd0, 1'b0, 1'b1);
    test_random_phase(100, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 1'b1, 1'b0);

    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d command words and %0d checked status words over %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("rest changes with beep: %0d, finished anti-cavitation trains: %0d",
             beeps_seen, sequences_done);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/prc_pkg.sv
hw/rtl/prc_step.sv
hw/rtl/pump_rest_cycle_controller.sv
sim/tb_pump_rest_cycle_controller.sv
